// ===== sv/lge_pkg.sv =====
package lge_pkg;

   // Default board limits.
   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;

   // Field widths of the channels and the register port.
   localparam int REQ_TYPE_W   = 2;
   localparam int COORD_W      = 6;
   localparam int STEP_COUNT_W = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 7;

   // Smallest legal board edge, border ring included.
   localparam int MIN_EDGE = 3;

   // Reset value of both size registers.
   localparam logic [CSR_DATA_W-1:0] CSR_SIZE_RESET = 7'd64;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_RUN   = 2'd1,
      REQ_READ  = 2'd2
   } lge_req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOARD_WIDTH  = 1'b0,
      CSR_BOARD_HEIGHT = 1'b1
   } lge_csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic decode;
      logic clr_step;
      logic cell_rd;
      logic cell_op;
      logic gen_step;
      logic rsp_load;
   } lge_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic cell_go;
      logic run_go;
      logic clr_last;
      logic gen_wrap;
      logic gen_last;
   } lge_status_type;

endpackage

// ===== sv/lge_req_if.sv =====
interface lge_req_if;
   import lge_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [COORD_W-1:0]      col;
   logic [COORD_W-1:0]      row;
   logic                    cell_in;
   logic [STEP_COUNT_W-1:0] step_count;

   modport source (
      output valid, req_type, col, row, cell_in, step_count,
      input  ready
   );

   modport sink (
      input  valid, req_type, col, row, cell_in, step_count,
      output ready
   );

endinterface

// ===== sv/lge_rsp_if.sv =====
interface lge_rsp_if;

   logic valid;
   logic ready;
   logic cell_out;
   logic status;

   modport source (
      output valid, cell_out, status,
      input  ready
   );

   modport sink (
      input  valid, cell_out, status,
      output ready
   );

endinterface

// ===== sv/life_generation_engine.sv =====
// Channel   Direction  Handshake          Beat contents
// req_ch    in         valid / ready      req_type, col, row, cell_in, step_count
// rsp_ch    out        valid / ready      cell_out, status
// csr_*     in         csr_wr_en only     csr_index, csr_wdata (board_width, board_height)
//
// A write or read of an interior cell goes from DECODE through CELL_RD and CELL_OP to
// FINISH; one off the board or on the border ring, and the unused code, skip to FINISH.
// During a run the generation sweep passes every memory row once per generation, one row
// per cycle, through the single read and write port of the board.
// After reset a clearing pass writes zero to all MAX_HEIGHT rows; req_ch is not ready
// during that pass, while register writes are taken as ever.
// A waiting result does not stop the next request being accepted and worked on; only its
// own hand-over to the output register waits until rsp_ch is free.
module life_generation_engine #(
   parameter int MAX_WIDTH  = lge_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lge_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   lge_req_if.sink                         req_ch,
   lge_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [lge_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lge_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lge_pkg::*;

   // The controller sequences the work; the datapath holds the board memory, the
   // request, the sweep counter and the neighbour-count logic.
   lge_cmd_type    cmd;
   lge_status_type st;

   lge_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .cmd      (cmd),
      .st       (st)
   );

   // Each generation reads a three-row window from the board, computes the middle
   // row and writes it back two rows behind the read pointer, so one memory is enough.
   // Rows and columns outside the interior are written as zero on every generation.
   lge_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_type      (req_ch.req_type),
      .req_col       (req_ch.col),
      .req_row       (req_ch.row),
      .req_cell_in   (req_ch.cell_in),
      .req_step_count(req_ch.step_count),
      .rsp_cell_out  (rsp_ch.cell_out),
      .rsp_status    (rsp_ch.status),
      .cmd           (cmd),
      .st            (st)
   );

endmodule

// ===== sv/lge_ram.sv =====
module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lge_ctrl.sv =====
module lge_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lge_pkg::lge_cmd_type    cmd,
   input  lge_pkg::lge_status_type st
);
   import lge_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_DECODE  = 7'b0000100,
      ST_CELL_RD = 7'b0001000,
      ST_CELL_OP = 7'b0010000,
      ST_GEN     = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } lge_state_type;

   lge_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (st.cell_go) begin
               state_in = ST_CELL_RD;
            end else if (st.run_go) begin
               state_in = ST_GEN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = ST_CELL_OP;
         end
         ST_CELL_OP: begin
            cmd.cell_op = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_GEN: begin
            cmd.gen_step = 1'b1;
            if (st.gen_wrap && st.gen_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.decode, cmd.clr_step, cmd.cell_rd,
                cmd.cell_op, cmd.gen_step, cmd.rsp_load}))
      else $error("more than one datapath command in a cycle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result still waits");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN && st.gen_wrap && st.gen_last) |=> (state_ff == ST_FINISH))
      else $error("run did not finish after its last generation");
`endif

endmodule

// ===== sv/lge_datapath.sv =====
module lge_datapath #(
   parameter int MAX_WIDTH  = lge_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = lge_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lge_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lge_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [lge_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [lge_pkg::COORD_W-1:0]        req_col,
   input  logic [lge_pkg::COORD_W-1:0]        req_row,
   input  logic                               req_cell_in,
   input  logic [lge_pkg::STEP_COUNT_W-1:0]   req_step_count,
   output logic                               rsp_cell_out,
   output logic                               rsp_status,
   input  lge_pkg::lge_cmd_type               cmd,
   output lge_pkg::lge_status_type            st
);
   import lge_pkg::*;

   localparam int RW  = MAX_WIDTH;
   localparam int AW  = $clog2(MAX_HEIGHT);
   localparam int CW  = $clog2(MAX_HEIGHT + 2);
   localparam int YW  = ((CW > CSR_DATA_W) ? CW : CSR_DATA_W) + 1;
   localparam int CLW = $clog2(MAX_WIDTH);

   // Size registers and the active board size derived from them.
   logic [CSR_DATA_W-1:0] board_width_ff, board_width_in;
   logic [CSR_DATA_W-1:0] board_height_ff, board_height_in;
   logic [CSR_DATA_W-1:0] act_w, act_h;
   logic [RW-1:0]         cmask;

   // Request held for the duration of its work.
   logic [REQ_TYPE_W-1:0]   req_type_ff;
   logic [COORD_W-1:0]      req_col_ff, req_row_ff;
   logic                    req_cell_ff;
   logic [STEP_COUNT_W-1:0] steps_ff, steps_in;

   // Result being formed and result on offer.
   logic res_cell_ff, res_cell_in, res_status_ff, res_status_in;
   logic rsp_cell_ff, rsp_status_ff;

   // Sweep counter and the three-row window of the generation sweep.
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] up_ff, mid_ff;
   logic          mid_int_ff;
   logic [RW-1:0] dn_seen, new_row, gen_row, cell_row;
   logic [YW-1:0] cnt_x, h_x;
   logic          dn_int;

   logic is_access, out_of_range, inner;
   logic [AW-1:0]  req_addr;
   logic [CLW-1:0] col_idx;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic [RW-1:0]  wr_data, rd_data;

   // Configuration registers.
   always_comb begin
      board_width_in  = board_width_ff;
      board_height_in = board_height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BOARD_WIDTH:  board_width_in  = csr_wdata;
            CSR_BOARD_HEIGHT: board_height_in = csr_wdata;
            default: begin
               board_width_in  = board_width_ff;
               board_height_in = board_height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_width_ff  <= CSR_SIZE_RESET;
         board_height_ff <= CSR_SIZE_RESET;
      end else begin
         board_width_ff  <= board_width_in;
         board_height_ff <= board_height_in;
      end
   end

   // Saturate the sizes into the legal range.
   always_comb begin
      if (int'(board_width_ff) < MIN_EDGE) begin
         act_w = CSR_DATA_W'(MIN_EDGE);
      end else if (int'(board_width_ff) > MAX_WIDTH) begin
         act_w = CSR_DATA_W'(MAX_WIDTH);
      end else begin
         act_w = board_width_ff;
      end
      if (int'(board_height_ff) < MIN_EDGE) begin
         act_h = CSR_DATA_W'(MIN_EDGE);
      end else if (int'(board_height_ff) > MAX_HEIGHT) begin
         act_h = CSR_DATA_W'(MAX_HEIGHT);
      end else begin
         act_h = board_height_ff;
      end
   end

   // Interior columns are 1 to width-2.
   always_comb begin
      for (int i = 0; i < RW; i++) begin
         cmask[i] = (i != 0) && ((i + 2) <= int'(act_w));
      end
   end

   // Request decode.
   assign is_access    = req_type_ff inside {REQ_WRITE, REQ_READ};
   assign out_of_range = ({1'b0, req_col_ff} >= act_w) || ({1'b0, req_row_ff} >= act_h);
   assign inner        = (req_col_ff != '0) && (({1'b0, req_col_ff} + 7'd1) < act_w) &&
                         (req_row_ff != '0) && (({1'b0, req_row_ff} + 7'd1) < act_h);
   assign req_addr     = AW'(req_row_ff);
   assign col_idx      = CLW'(req_col_ff);

   assign st.cell_go  = is_access && !out_of_range && inner;
   assign st.run_go   = (req_type_ff == REQ_RUN) && (steps_ff != '0);
   assign st.clr_last = (cnt_ff == CW'(MAX_HEIGHT - 1));
   assign st.gen_wrap = (cnt_ff == CW'(MAX_HEIGHT + 1));
   assign st.gen_last = (steps_ff == STEP_COUNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_type_ff <= req_type;
         req_col_ff  <= req_col;
         req_row_ff  <= req_row;
         req_cell_ff <= req_cell_in;
      end
   end

   // Sweep counter and generation count.
   always_comb begin
      cnt_in   = cnt_ff;
      steps_in = steps_ff;
      if (cmd.load_req) begin
         steps_in = req_step_count;
      end
      if (cmd.clr_step) begin
         cnt_in = st.clr_last ? '0 : cnt_ff + CW'(1);
      end
      if (cmd.gen_step) begin
         cnt_in = st.gen_wrap ? '0 : cnt_ff + CW'(1);
         if (st.gen_wrap) begin
            steps_in = steps_ff - STEP_COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      steps_ff <= steps_in;
   end

   // The row now leaving the memory is row cnt-1; it counts only when interior.
   assign cnt_x   = YW'(cnt_ff);
   assign h_x     = YW'(act_h);
   assign dn_int  = (cnt_x >= YW'(2)) && ((cnt_x + YW'(1)) <= h_x);
   assign dn_seen = dn_int ? (rd_data & cmask) : '0;

   always_ff @(posedge clock) begin
      if (cmd.gen_step) begin
         up_ff      <= mid_ff;
         mid_ff     <= dn_seen;
         mid_int_ff <= dn_int;
      end
   end

   // B3/S23 on every column of the middle row.
   always_comb begin
      logic [RW-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
      logic [3:0]    nsum;
      up_l  = up_ff << 1;
      up_r  = up_ff >> 1;
      mid_l = mid_ff << 1;
      mid_r = mid_ff >> 1;
      dn_l  = dn_seen << 1;
      dn_r  = dn_seen >> 1;
      for (int i = 0; i < RW; i++) begin
         nsum = 4'(up_l[i]) + 4'(up_ff[i]) + 4'(up_r[i]) + 4'(mid_l[i]) +
                4'(mid_r[i]) + 4'(dn_l[i]) + 4'(dn_seen[i]) + 4'(dn_r[i]);
         new_row[i] = (nsum == 4'd3) || ((nsum == 4'd2) && mid_ff[i]);
      end
   end

   assign gen_row = new_row & cmask & {RW{mid_int_ff}};

   always_comb begin
      cell_row          = rd_data;
      cell_row[col_idx] = req_cell_ff;
   end

   // Memory port steering.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = cnt_ff[AW-1:0];
      end
      if (cmd.cell_rd) begin
         rd_en   = 1'b1;
         rd_addr = req_addr;
      end
      if (cmd.cell_op && (req_type_ff == REQ_WRITE)) begin
         wr_en   = 1'b1;
         wr_addr = req_addr;
         wr_data = cell_row;
      end
      if (cmd.gen_step) begin
         rd_en   = (cnt_ff < CW'(MAX_HEIGHT));
         rd_addr = cnt_ff[AW-1:0];
         wr_en   = (cnt_ff >= CW'(2));
         wr_addr = AW'(cnt_ff - CW'(2));
         wr_data = gen_row;
      end
   end

   lge_ram #(
      .WIDTH(RW),
      .DEPTH(MAX_HEIGHT)
   ) u_board (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Result forming and the output register.
   always_comb begin
      res_cell_in   = res_cell_ff;
      res_status_in = res_status_ff;
      if (cmd.decode) begin
         res_cell_in   = 1'b0;
         res_status_in = is_access && out_of_range;
      end
      if (cmd.cell_op && (req_type_ff == REQ_READ)) begin
         res_cell_in = rd_data[col_idx];
      end
   end

   always_ff @(posedge clock) begin
      res_cell_ff   <= res_cell_in;
      res_status_ff <= res_status_in;
      if (cmd.rsp_load) begin
         rsp_cell_ff   <= res_cell_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef SYNTHESIS
   a_port_apart: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("board memory read and written at the same row");
`endif

endmodule

// ===== tb/sv/tb_life_generation_engine.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the cell board engine. Requests go in one beat at a time on
// req_ch, and every beat gives exactly one reply beat on rsp_ch. A behavioural copy of
// the board in this module is updated as each request beat is accepted. The reply it
// predicts is queued, and the checker compares each reply beat against the oldest
// entry in that queue.
module tb_life_generation_engine;
   import lge_pkg::*;

   localparam int BOARD_COLS = DEF_MAX_WIDTH;
   localparam int BOARD_ROWS = DEF_MAX_HEIGHT;

   // Code 3 is left unassigned by the block. It must still answer with a clean reply.
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // The reply the block should give for one request beat.
   typedef struct packed {
      logic cell_out;
      logic status;
   } cell_reply_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lge_req_if req_ch ();
   lge_rsp_if rsp_ch ();

   life_generation_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The predicted board and the raw values of the two size registers.
   logic [BOARD_COLS-1:0] model_board [BOARD_ROWS];
   logic [CSR_DATA_W-1:0] shadow_width;
   logic [CSR_DATA_W-1:0] shadow_height;

   cell_reply_type pending_replies [$];

   int beats_sent [4];
   int replies_checked;
   int mismatches;
   int size_settings;
   int generations_predicted;

   // Sender burst state: how many beats remain before the next gap.
   int burst_left;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // A size register is saturated into the legal range before it is used.
   function automatic int clamp_edge(input logic [CSR_DATA_W-1:0] raw, input int top);
      if (raw < MIN_EDGE) return MIN_EDGE;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   function automatic int active_cols();
      return clamp_edge(shadow_width, BOARD_COLS);
   endfunction

   function automatic int active_rows();
      return clamp_edge(shadow_height, BOARD_ROWS);
   endfunction

   // One B3/S23 generation over the interior. Each row's neighbour count is built as a
   // bit-sliced counter: ones and twos hold the low two bits of the count per column,
   // and many flags four or more. Cells outside the interior are read as dead and
   // come out cleared, which is what wipes stale cells after a size change.
   task automatic advance_generation();
      int w;
      int h;
      logic [BOARD_COLS-1:0] mask;
      logic [BOARD_COLS-1:0] above;
      logic [BOARD_COLS-1:0] centre;
      logic [BOARD_COLS-1:0] below;
      logic [BOARD_COLS-1:0] ones;
      logic [BOARD_COLS-1:0] twos;
      logic [BOARD_COLS-1:0] many;
      logic [BOARD_COLS-1:0] carry;
      logic [BOARD_COLS-1:0] fresh [BOARD_ROWS];
      logic [BOARD_COLS-1:0] nbr [8];
      w = active_cols();
      h = active_rows();
      mask = ((64'd1 << (w - 2)) - 64'd1) << 1;
      for (int y = 0; y < BOARD_ROWS; y++) fresh[y] = '0;
      for (int y = 1; y < h - 1; y++) begin
         above  = (y - 1 >= 1) ? (model_board[y - 1] & mask) : '0;
         centre = model_board[y] & mask;
         below  = (y + 1 < h - 1) ? (model_board[y + 1] & mask) : '0;
         nbr[0] = above << 1;
         nbr[1] = above;
         nbr[2] = above >> 1;
         nbr[3] = centre << 1;
         nbr[4] = centre >> 1;
         nbr[5] = below << 1;
         nbr[6] = below;
         nbr[7] = below >> 1;
         ones = '0;
         twos = '0;
         many = '0;
         foreach (nbr[i]) begin
            carry = ones & nbr[i];
            ones  = ones ^ nbr[i];
            many  = many | (twos & carry);
            twos  = twos ^ carry;
         end
         // Birth on exactly three, survival on two or three.
         fresh[y] = twos & ~many & (ones | centre) & mask;
      end
      for (int y = 0; y < BOARD_ROWS; y++) model_board[y] = fresh[y];
      generations_predicted++;
   endtask

   // Applies one accepted request to the predicted board and returns its reply.
   task automatic apply_request(input logic [REQ_TYPE_W-1:0] kind,
                                input logic [COORD_W-1:0] col,
                                input logic [COORD_W-1:0] row,
                                input logic cell_value,
                                input logic [STEP_COUNT_W-1:0] steps,
                                output cell_reply_type reply);
      int w;
      int h;
      bit inner;
      w = active_cols();
      h = active_rows();
      reply = '0;
      case (kind)
         REQ_WRITE, REQ_READ: begin
            if (col >= w || row >= h) begin
               reply.status = 1'b1;
            end else begin
               // Border cells ignore writes and always read as dead.
               inner = col >= 1 && col + 1 < w && row >= 1 && row + 1 < h;
               if (inner && kind == REQ_WRITE) model_board[row][col] = cell_value;
               if (inner && kind == REQ_READ) reply.cell_out = model_board[row][col];
            end
         end
         REQ_RUN: begin
            repeat (steps) advance_generation();
         end
         default: begin
         end
      endcase
   endtask

   task automatic log_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Sends one request beat. The sender works in bursts of random length; between
   // bursts valid drops for a random gap, and some bursts follow on with no gap at all.
   // The task is entered and left at a falling edge with valid low.
   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [COORD_W-1:0] col,
                               input logic [COORD_W-1:0] row,
                               input logic cell_value,
                               input logic [STEP_COUNT_W-1:0] steps);
      cell_reply_type reply;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid      = 1'b1;
      req_ch.req_type   = kind;
      req_ch.col        = col;
      req_ch.row        = row;
      req_ch.cell_in    = cell_value;
      req_ch.step_count = steps;
      do @(posedge clock); while (!req_ch.ready);
      apply_request(kind, col, row, cell_value, steps, reply);
      pending_replies.push_back(reply);
      beats_sent[kind]++;
      @(negedge clock);
      // A following call raises valid again in this same step if it sends at once.
      req_ch.valid = 1'b0;
   endtask

   // Holds the sender back until every predicted reply has been seen.
   task automatic wait_for_replies();
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   // Size registers are only written with the block idle, so drain first.
   task automatic write_register(input lge_csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_for_replies();
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (index == CSR_BOARD_WIDTH) shadow_width = value;
      else shadow_height = value;
      size_settings++;
   endtask

   // Mostly short runs, sometimes a longer one and now and then a very long one.
   function automatic logic [STEP_COUNT_W-1:0] pick_steps();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel == 0) return STEP_COUNT_W'($urandom_range(60, 120));
      if (sel < 10) return '0;
      if (sel < 70) return STEP_COUNT_W'($urandom_range(1, 3));
      if (sel < 90) return STEP_COUNT_W'($urandom_range(4, 8));
      return STEP_COUNT_W'($urandom_range(9, 20));
   endfunction

   // Coordinates mostly fall in a window of interest; one in ten spans the full field.
   function automatic logic [COORD_W-1:0] pick_coord(input int base, input int span);
      int v;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 63);
      else v = base + $urandom_range(0, span - 1);
      if (v > 63) v = 63;
      return v[COORD_W-1:0];
   endfunction

   // Two opposite corners of the interior, every edge of the border ring, and the unused code.
   task automatic test_cell_access();
      send_request(REQ_WRITE, 6'd1, 6'd1, 1'b1, 16'h0000);
      send_request(REQ_WRITE, 6'd62, 6'd62, 1'b1, 16'hFFFF);
      send_request(REQ_WRITE, 6'd0, 6'd0, 1'b1, 16'h0000);
      send_request(REQ_WRITE, 6'd63, 6'd63, 1'b1, 16'h0000);
      send_request(REQ_WRITE, 6'd63, 6'd10, 1'b1, 16'h0000);
      send_request(REQ_READ, 6'd1, 6'd1, 1'b0, 16'h0000);
      send_request(REQ_READ, 6'd62, 6'd62, 1'b1, 16'hFFFF);
      send_request(REQ_READ, 6'd0, 6'd0, 1'b0, 16'h0000);
      send_request(REQ_READ, 6'd63, 6'd63, 1'b0, 16'h0000);
      send_request(REQ_WRITE, 6'd62, 6'd62, 1'b0, 16'h0000);
      send_request(REQ_READ, 6'd62, 6'd62, 1'b0, 16'h0000);
      send_request(REQ_UNUSED, 6'd63, 6'd63, 1'b1, 16'hFFFF);
   endtask

   // A blinker: a zero-step run must leave it alone, and each generation flips it.
   task automatic test_generation_rules();
      send_request(REQ_WRITE, 6'd10, 6'd20, 1'b1, 16'h0000);
      send_request(REQ_WRITE, 6'd11, 6'd20, 1'b1, 16'h0000);
      send_request(REQ_WRITE, 6'd12, 6'd20, 1'b1, 16'h0000);
      send_request(REQ_RUN, 6'd0, 6'd0, 1'b0, 16'd0);
      send_request(REQ_READ, 6'd11, 6'd19, 1'b0, 16'h0000);
      send_request(REQ_RUN, 6'd0, 6'd0, 1'b0, 16'd1);
      send_request(REQ_READ, 6'd11, 6'd19, 1'b0, 16'h0000);
      send_request(REQ_READ, 6'd10, 6'd20, 1'b0, 16'h0000);
      send_request(REQ_RUN, 6'd0, 6'd0, 1'b0, 16'd2);
   endtask

   // Saturation of the size registers, coordinates off the board, and a live cell
   // that ends up on the border after the board shrinks.
   task automatic test_board_limits();
      send_request(REQ_WRITE, 6'd3, 6'd1, 1'b1, 16'h0000);
      write_register(CSR_BOARD_WIDTH, 7'd4);
      write_register(CSR_BOARD_HEIGHT, 7'd0);
      send_request(REQ_READ, 6'd3, 6'd1, 1'b0, 16'h0000);
      send_request(REQ_READ, 6'd4, 6'd1, 1'b0, 16'h0000);
      send_request(REQ_WRITE, 6'd1, 6'd3, 1'b1, 16'h0000);
      send_request(REQ_RUN, 6'd0, 6'd0, 1'b0, 16'd1);
      write_register(CSR_BOARD_WIDTH, 7'd127);
      write_register(CSR_BOARD_HEIGHT, 7'd127);
      send_request(REQ_READ, 6'd3, 6'd1, 1'b0, 16'h0000);
   endtask

   // Each phase picks a board size, seeds a window of it with live cells, then mixes
   // runs, reads and further writes so that the patterns evolve and are read back.
   task automatic test_random_boards(input int phases, input int beats_per_phase);
      int raw_w;
      int raw_h;
      int w;
      int h;
      int base_c;
      int base_r;
      int span_c;
      int span_r;
      int seeds;
      int pick;
      logic [COORD_W-1:0] c;
      logic [COORD_W-1:0] r;
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 7))
            0: begin
               raw_w = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
               raw_h = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
            end
            1: begin
               raw_w = $urandom_range(0, 3);
               raw_h = $urandom_range(0, 3);
            end
            2: begin
               raw_w = $urandom_range(4, 12);
               raw_h = $urandom_range(4, 12);
            end
            3: begin
               raw_w = $urandom_range(3, 6);
               raw_h = $urandom_range(48, 64);
            end
            4: begin
               raw_w = $urandom_range(48, 64);
               raw_h = $urandom_range(3, 6);
            end
            5: begin
               raw_w = $urandom_range(0, 127);
               raw_h = $urandom_range(0, 127);
            end
            default: begin
               raw_w = $urandom_range(5, 16);
               raw_h = $urandom_range(5, 16);
            end
         endcase
         write_register(CSR_BOARD_WIDTH, raw_w[CSR_DATA_W-1:0]);
         write_register(CSR_BOARD_HEIGHT, raw_h[CSR_DATA_W-1:0]);
         w = active_cols();
         h = active_rows();
         // Small boards are covered whole, one place past the edge included; on large
         // ones a window is chosen so that the seeded cells are dense enough to evolve.
         if (w <= 16) begin
            base_c = 0;
            span_c = w + 1;
         end else begin
            base_c = $urandom_range(0, w - 12);
            span_c = 12;
         end
         if (h <= 16) begin
            base_r = 0;
            span_r = h + 1;
         end else begin
            base_r = $urandom_range(0, h - 12);
            span_r = 12;
         end
         seeds = span_c * span_r / 3;
         if (seeds > 30) seeds = 30;
         for (int n = 0; n < beats_per_phase; n++) begin
            c = pick_coord(base_c, span_c);
            r = pick_coord(base_r, span_r);
            pick = (n < seeds) ? 0 : $urandom_range(0, 99);
            if (pick < 25)
               send_request(REQ_WRITE, c, r, $urandom_range(0, 3) != 0,
                            STEP_COUNT_W'($urandom_range(0, 65535)));
            else if (pick < 38)
               send_request(REQ_RUN, c, r, 1'($urandom_range(0, 1)), pick_steps());
            else if (pick < 96)
               send_request(REQ_READ, c, r, 1'($urandom_range(0, 1)),
                            STEP_COUNT_W'($urandom_range(0, 65535)));
            else
               send_request(REQ_UNUSED, c, r, 1'($urandom_range(0, 1)),
                            STEP_COUNT_W'($urandom_range(0, 65535)));
         end
      end
   endtask

   // The receiver stalls on a repeating twelve-bit ready pattern that is itself redrawn at
   // random: sometimes always ready, sometimes mostly ready, sometimes mostly stalled.
   initial begin : receiver_stalls
      logic [11:0] pattern;
      int phase;
      rsp_ch.ready = 1'b0;
      pattern = '1;
      phase = 0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: pattern = '1;
               1: pattern = 12'($urandom);
               2: pattern = 12'($urandom | $urandom);
               default: pattern = 12'($urandom & $urandom);
            endcase
            pattern[0] = 1'b1;
         end
         rsp_ch.ready = pattern[phase % 12];
         phase++;
      end
   end

   // Each reply beat is compared with the oldest prediction.
   always @(posedge clock) begin : check_replies
      cell_reply_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            log_mismatch($sformatf("reply beat with none expected (cell_out %0b, status %0b)",
                                   rsp_ch.cell_out, rsp_ch.status));
         end else begin
            due = pending_replies.pop_front();
            if (rsp_ch.cell_out !== due.cell_out)
               log_mismatch($sformatf("reply %0d cell_out expected %0b, got %0b",
                                      replies_checked, due.cell_out, rsp_ch.cell_out));
            if (rsp_ch.status !== due.status)
               log_mismatch($sformatf("reply %0d status expected %0b, got %0b",
                                      replies_checked, due.status, rsp_ch.status));
         end
         replies_checked++;
      end
   end

   // Hard stop should the block hang; far beyond the slowest legitimate run.
   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.col = '0;
      req_ch.row = '0;
      req_ch.cell_in = 1'b0;
      req_ch.step_count = '0;
      for (int y = 0; y < BOARD_ROWS; y++) model_board[y] = '0;
      shadow_width = CSR_SIZE_RESET;
      shadow_height = CSR_SIZE_RESET;
      foreach (beats_sent[i]) beats_sent[i] = 0;
      replies_checked = 0;
      mismatches = 0;
      size_settings = 0;
      generations_predicted = 0;
      burst_left = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The clearing pass after reset simply shows up as req_ch not yet ready.
      test_cell_access();
      test_generation_rules();
      test_board_limits();
      test_random_boards(25, 75);

      wait_for_replies();
      // Wait on for any stray reply beat to surface.
      repeat (16) @(posedge clock);

      $display("Covered %0d write, %0d run, %0d read and %0d unused-code beats",
               beats_sent[REQ_WRITE], beats_sent[REQ_RUN], beats_sent[REQ_READ],
               beats_sent[REQ_UNUSED]);
      $display("over %0d size writes; %0d generations predicted, %0d replies checked, %0d mismatches.",
               size_settings, generations_predicted, replies_checked, mismatches);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
